// ===== src/slem_pkg.sv =====
// ----------------------------------------------------------------------------
// slem_pkg
// Shared constants and types for the sized little-endian memory.
// ----------------------------------------------------------------------------
package slem_pkg;

  localparam int MEM_BYTES   = 65536;
  localparam int BLOCK_BYTES = 256;
  localparam int BLK_COUNT   = MEM_BYTES / BLOCK_BYTES;
  localparam int ADDR_W      = $clog2(MEM_BYTES);
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int BLK_W       = ADDR_W - OFF_W;

  localparam int LIMIT_W     = 17;
  localparam int LIMIT_RESET = 65536;
  // width that holds both the limit register and the store size
  localparam int CMP_W       = (LIMIT_W > ADDR_W + 1) ? LIMIT_W : ADDR_W + 1;

  localparam int DATA_W      = 64;
  localparam int BYTE_IDX_W  = 3;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACCESS,
    ST_CLEAR,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ===== src/sized_little_endian_memory.sv =====
// ----------------------------------------------------------------------------
// sized_little_endian_memory
// Byte-addressed store with 1/2/4/8-byte unaligned little-endian accesses,
// a configurable limit and per-block presence marks.
// ----------------------------------------------------------------------------
// Order from accept to done: CHECK, then DONE if refused. A write stores its N
//   bytes (N = 1, 2, 4 or 8) in ACCESS, then DONE; a read goes ACCESS, DRAIN, DONE.
//   A write reaching an absent block first clears it in CLEAR (at most two blocks).
// Throughput: one request at a time, one byte per cycle through the store
//   port; busy stays high until the done cycle ends. The receiver cannot stall.
// Reset: synchronous; all blocks marked absent (read as zero), limit = 65536.
module sized_little_endian_memory import slem_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                func,
  input  logic [1:0]          access_size,
  input  logic [DATA_W-1:0]   address,
  input  logic [DATA_W-1:0]   write_data,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata,
  output logic                done,
  output logic [DATA_W-1:0]   read_data,
  output logic                range_error
);

  state_t state, state_next;

  logic [LIMIT_W-1:0]    memory_limit;
  logic [BLK_COUNT-1:0]  present;

  // request registers
  logic                  op_write;
  logic [1:0]            size;
  logic [ADDR_W-1:0]     addr_lo;
  logic                  addr_hi;
  logic [DATA_W-1:0]     wdata;
  logic [BYTE_IDX_W-1:0] cnt;
  logic                  err;
  logic [DATA_W-1:0]     rdata;

  // clearing sweep
  logic [BLK_W-1:0]      clr_blk;
  logic [OFF_W-1:0]      clr_idx;

  // read return pipeline
  logic                  rd_pend;
  logic [BYTE_IDX_W-1:0] rd_idx;
  logic                  rd_pres;

  // store
  logic [7:0]            mem [MEM_BYTES];
  logic [7:0]            mem_q;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_addr;
  logic [7:0]            mem_wd;

  // datapath
  logic [ADDR_W-1:0]     byte_addr;
  logic [BLK_W-1:0]      cur_blk;
  logic                  cur_pres;
  logic                  last_byte;
  logic                  clr_last;
  logic [CMP_W-1:0]      lim;
  logic [CMP_W-1:0]      nbytes;
  logic                  refuse;

  assign byte_addr = addr_lo + ADDR_W'(cnt);
  assign cur_blk   = byte_addr[ADDR_W-1 -: BLK_W];
  assign cur_pres  = present[cur_blk];
  assign last_byte = (cnt == BYTE_IDX_W'((1 << size) - 1));
  assign clr_last  = (clr_idx == {OFF_W{1'b1}});

  // limit check: a limit above the store acts as the store size
  assign lim    = (CMP_W'(memory_limit) > CMP_W'(MEM_BYTES)) ? CMP_W'(MEM_BYTES)
                                                             : CMP_W'(memory_limit);
  assign nbytes = CMP_W'(1) << size;
  assign refuse = addr_hi || (lim < nbytes) || (CMP_W'(addr_lo) > lim - nbytes);

  assign busy        = (state != ST_IDLE);
  assign done        = (state == ST_DONE);
  assign read_data   = rdata;
  assign range_error = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = byte_addr;
    mem_wd     = wdata[{cnt, 3'b000} +: 8];
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = refuse ? ST_DONE : ST_ACCESS;
      end
      ST_ACCESS: begin
        if (op_write == FUNC_WRITE) begin
          if (!cur_pres) begin
            state_next = ST_CLEAR;
          end else begin
            mem_we = 1'b1;
            if (last_byte) state_next = ST_DONE;
          end
        end else if (last_byte) begin
          state_next = ST_DRAIN;
        end
      end
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = {clr_blk, clr_idx};
        mem_wd   = 8'h00;
        if (clr_last) state_next = ST_ACCESS;
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      memory_limit <= LIMIT_W'(LIMIT_RESET);
      present      <= '0;
      rd_pend      <= 1'b0;
    end else begin
      if (cfg_we) memory_limit <= cfg_wdata;
      if (state == ST_CLEAR && clr_last) present[clr_blk] <= 1'b1;
      rd_pend <= (state == ST_ACCESS) && (op_write == FUNC_READ);
    end
  end

  // request and data registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_write <= func;
      size     <= access_size;
      addr_lo  <= address[ADDR_W-1:0];
      addr_hi  <= |address[DATA_W-1:ADDR_W];
      wdata    <= write_data;
    end
    if (state == ST_CHECK) begin
      rdata <= '0;
      err   <= refuse;
      cnt   <= '0;
    end
    if (state == ST_ACCESS) begin
      if (op_write == FUNC_WRITE && !cur_pres) begin
        clr_blk <= cur_blk;
        clr_idx <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
    if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
    rd_idx  <= cnt;
    rd_pres <= cur_pres;
    // byte of an absent block reads as zero
    if (rd_pend) rdata[{rd_idx, 3'b000} +: 8] <= rd_pres ? mem_q : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  // assertions
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && range_error) |-> (read_data == '0))
    else $error("refused request returned data");

  a_write_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && op_write == FUNC_WRITE) |-> (read_data == '0))
    else $error("write returned data");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  a_clear_on_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (op_write == FUNC_WRITE && !present[clr_blk]))
    else $error("block clear outside a first write");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule
